// ----- hw/rtl/gelu_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the GELU (tanh form) pipeline.
// Holds the tanh table generator used by gelu_tanh; no dependencies.
package gelu_pkg;

  // Default configuration handed down from the top level
  localparam int DATA_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int TANH_DEPTH_DEF  = 256;

  // Scaling coefficients in Q20
  localparam int                CQ_SHIFT = 20;
  localparam int                C1_W     = 20;
  localparam int                C2_W     = 16;
  localparam logic [C1_W-1:0]   C1_Q20   = 20'd836643;   // 0.797885
  localparam logic [C2_W-1:0]   C2_Q20   = 16'd46887;    // 0.044715

  // Cubic terms saturate at 2^31-1
  localparam int                CUBE_W   = 31;
  localparam logic [CUBE_W-1:0] CUBE_CAP = '1;

  // tanh samples are Q16, with 1.0 included
  localparam int                TH_W     = 17;
  localparam logic [TH_W-1:0]   TH_ONE   = 17'h10000;

  // Control sideband that travels with each request
  typedef struct packed {
    logic valid;
    logic neg;
  } gelu_ctl_t;

  // Width of the scaled tanh argument u for a given data width
  function automatic int u_width(input int dw);
    int r4;
    int inw;
    r4  = CUBE_W + C2_W + 1 - CQ_SHIFT;
    inw = ((dw > r4) ? dw : r4) + 1;
    return inw + C1_W + 1 - CQ_SHIFT;
  endfunction

  // Shift-subtract division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table entry i: tanh(4*i/depth) in Q16, via exp(-r) series then six squarings
  function automatic logic [TH_W-1:0] tanh_entry(input int unsigned i, input int unsigned depth);
    logic [63:0] q30;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] res;
    q30  = 64'd1 << 30;
    r    = udiv64(64'(i) << 30, 64'(depth) * 64'd8);
    e    = q30;
    term = q30;
    for (int k = 1; k <= 7; k++) begin
      term = udiv64((term * r) >> 30, 64'(k));
      if ((k & 1) != 0) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int s = 0; s < 6; s++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    num = (q30 - e) << 16;
    den = q30 + e;
    res = udiv64(num + (den >> 1), den);
    return res[TH_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/gelu_cube.sv -----
// Four-stage arithmetic front end: x^2, x^3, x + c2*x^3, then scaling by c1.
// Depends on gelu_pkg for coefficients, cap and control struct.
module gelu_cube
  import gelu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gelu_ctl_t                            ctl_i,
  input  logic [DATA_WIDTH-1:0]                a_i,
  output gelu_ctl_t                            ctl_o,
  output logic [DATA_WIDTH-1:0]                a_o,
  output logic [u_width(DATA_WIDTH)-1:0]       u_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int XW   = CUBE_W;
  localparam int SQ_W = 2 * DW;
  localparam int S1_W = (SQ_W + 1 > XW + 1) ? SQ_W + 1 : XW + 1;
  localparam int P3_W = XW + DW;
  localparam int S3_W = P3_W + 1;
  localparam int P4_W = XW + C2_W;
  localparam int R4_W = P4_W + 1 - CQ_SHIFT;
  localparam int IN_W = ((DW > R4_W) ? DW : R4_W) + 1;
  localparam int P5_W = IN_W + C1_W;
  localparam int U_W  = u_width(DATA_WIDTH);

  localparam logic [S1_W-1:0] RND1 = S1_W'(1) << (F - 1);
  localparam logic [S3_W-1:0] RND3 = S3_W'(1) << (F - 1);
  localparam logic [P4_W:0]   RND4 = (P4_W + 1)'(1) << (CQ_SHIFT - 1);
  localparam logic [P5_W:0]   RND5 = (P5_W + 1)'(1) << (CQ_SHIFT - 1);

  gelu_ctl_t         c1_r, c2_r, c3_r, c4_r;
  logic [DW-1:0]     a1_r, a2_r, a3_r, a4_r;
  logic [XW-1:0]     x2_r, x2_nxt;
  logic [XW-1:0]     x3_r, x3_nxt;
  logic [IN_W-1:0]   inner_r, inner_nxt;
  logic [U_W-1:0]    u_r, u_nxt;

  logic [SQ_W-1:0]   sq;
  logic [S1_W-1:0]   s1, r1;
  logic [P3_W-1:0]   p3;
  logic [S3_W-1:0]   s3, r3;
  logic [P4_W-1:0]   p4;
  logic [P4_W:0]     s4;
  logic [P5_W-1:0]   p5;
  logic [P5_W:0]     s5;

  // Stage 1: square, round, saturate
  always_comb begin
    sq     = SQ_W'(a_i) * SQ_W'(a_i);
    s1     = S1_W'(sq) + RND1;
    r1     = s1 >> F;
    x2_nxt = (r1 > S1_W'(CUBE_CAP)) ? CUBE_CAP : r1[XW-1:0];
  end

  // Stage 2: cube, round, saturate
  always_comb begin
    p3     = P3_W'(x2_r) * P3_W'(a1_r);
    s3     = S3_W'(p3) + RND3;
    r3     = s3 >> F;
    x3_nxt = (r3 > S3_W'(CUBE_CAP)) ? CUBE_CAP : r3[XW-1:0];
  end

  // Stage 3: x + c2*x^3
  always_comb begin
    p4        = P4_W'(x3_r) * P4_W'(C2_Q20);
    s4        = {1'b0, p4} + RND4;
    inner_nxt = IN_W'(a2_r) + IN_W'(s4[P4_W:CQ_SHIFT]);
  end

  // Stage 4: scale by c1
  always_comb begin
    p5    = P5_W'(inner_r) * P5_W'(C1_Q20);
    s5    = {1'b0, p5} + RND5;
    u_nxt = s5[P5_W:CQ_SHIFT];
  end

  // Control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else begin
      c1_r <= ctl_i;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  // Data pipeline
  always_ff @(posedge clk) begin
    a1_r    <= a_i;
    a2_r    <= a1_r;
    a3_r    <= a2_r;
    a4_r    <= a3_r;
    x2_r    <= x2_nxt;
    x3_r    <= x3_nxt;
    inner_r <= inner_nxt;
    u_r     <= u_nxt;
  end

  assign ctl_o = c4_r;
  assign a_o   = a4_r;
  assign u_o   = u_r;

endmodule

// ----- hw/rtl/gelu_tanh.sv -----
// Three-stage tanh unit: table address split, registered table read, linear interpolation.
// Depends on gelu_pkg for the table generator and Q16 constants.
module gelu_tanh
  import gelu_pkg::*;
#(
  parameter int DATA_WIDTH       = DATA_WIDTH_DEF,
  parameter int FRAC_BITS        = FRAC_BITS_DEF,
  parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gelu_ctl_t                            ctl_i,
  input  logic [DATA_WIDTH-1:0]                a_i,
  input  logic [u_width(DATA_WIDTH)-1:0]       u_i,
  output gelu_ctl_t                            ctl_o,
  output logic [DATA_WIDTH-1:0]                a_o,
  output logic [TH_W-1:0]                      th_o
);

  localparam int DW    = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int U_W   = u_width(DATA_WIDTH);
  localparam int IDX_W = $clog2(TANH_TABLE_DEPTH);
  localparam int FR_W  = F + 2;
  localparam int P_W   = FR_W + IDX_W;
  localparam int MP_W  = TH_W + FR_W;

  localparam logic [U_W-1:0]   U_SAT    = U_W'(4) << F;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TANH_TABLE_DEPTH - 1);
  localparam logic [MP_W:0]    RND_FR   = (MP_W + 1)'(1) << (FR_W - 1);

  // Constant tanh samples over [0,4)
  logic [TH_W-1:0] rom [TANH_TABLE_DEPTH];

  for (genvar g = 0; g < TANH_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [TH_W-1:0] ENTRY = tanh_entry(g, TANH_TABLE_DEPTH);
    assign rom[g] = ENTRY;
  end

  gelu_ctl_t         c1_r, c2_r, c3_r;
  logic [DW-1:0]     a1_r, a2_r, a3_r;
  logic              sat1_r, sat2_r;
  logic [IDX_W-1:0]  idx_r;
  logic [FR_W-1:0]   fr1_r, fr2_r;
  logic [TH_W-1:0]   y0_r, y1_r;
  logic [TH_W-1:0]   th_r, th_nxt;

  logic [P_W-1:0]    p;
  logic              last;
  logic [IDX_W-1:0]  idx_up;
  logic signed [TH_W:0]   dlt;
  logic [TH_W-1:0]   dmag;
  logic [MP_W-1:0]   mp;
  logic [MP_W:0]     ms;
  logic [TH_W:0]     step;
  logic signed [TH_W+2:0] thw;

  // Stage 1: scale u by depth, split into index and fraction
  always_comb begin
    p = P_W'(u_i[FR_W-1:0]) * P_W'(TANH_TABLE_DEPTH);
  end

  // Stage 2: neighbour address; the last segment ends at 1.0
  always_comb begin
    last   = (idx_r == IDX_LAST);
    idx_up = last ? '0 : idx_r + 1'b1;
  end

  // Stage 3: interpolate on the magnitude of the slope, clamp to [0,1]
  always_comb begin
    dlt  = $signed({1'b0, y1_r}) - $signed({1'b0, y0_r});
    dmag = dlt[TH_W] ? TH_W'(-dlt) : TH_W'(dlt);
    mp   = MP_W'(dmag) * MP_W'(fr2_r);
    ms   = {1'b0, mp} + RND_FR;
    step = ms[MP_W:FR_W];
    thw  = dlt[TH_W] ? $signed({3'b000, y0_r}) - $signed({2'b00, step})
                     : $signed({3'b000, y0_r}) + $signed({2'b00, step});
    priority if (sat2_r) begin
      th_nxt = TH_ONE;
    end else if (thw < 0) begin
      th_nxt = '0;
    end else if (thw > $signed({3'b000, TH_ONE})) begin
      th_nxt = TH_ONE;
    end else begin
      th_nxt = thw[TH_W-1:0];
    end
  end

  // Control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else begin
      c1_r <= ctl_i;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  // Data pipeline and registered table reads
  always_ff @(posedge clk) begin
    a1_r   <= a_i;
    a2_r   <= a1_r;
    a3_r   <= a2_r;
    sat1_r <= (u_i >= U_SAT);
    sat2_r <= sat1_r;
    idx_r  <= p[P_W-1:FR_W];
    fr1_r  <= p[FR_W-1:0];
    fr2_r  <= fr1_r;
    y0_r   <= rom[idx_r];
    y1_r   <= last ? TH_ONE : rom[idx_up];
    th_r   <= th_nxt;
  end

  assign ctl_o = c3_r;
  assign a_o   = a3_r;
  assign th_o  = th_r;

endmodule

// ----- hw/rtl/gelu_tanh_forward.sv -----
// GELU, tanh form, on signed fixed-point activations: a fully pipelined unit that takes one
// request in every clock cycle and never asserts busy. Each result appears on out_y_value,
// marked by out_valid for one cycle, in request order; the receiver must take it then. The
// pipeline has ten register stages: sign and magnitude at the input, four in the cubic front
// end (square, cube, cubic coefficient, outer coefficient), three in the tanh unit (address
// split, registered table read, interpolation), the final product, and output rounding with
// saturation. Output saturates to the data range.
// Depends on gelu_pkg, gelu_cube and gelu_tanh.
module gelu_tanh_forward
  import gelu_pkg::*;
#(
  parameter int DATA_WIDTH       = DATA_WIDTH_DEF,
  parameter int FRAC_BITS        = FRAC_BITS_DEF,
  parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_x_value,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_y_value
);

  localparam int DW   = DATA_WIDTH;
  localparam int U_W  = u_width(DATA_WIDTH);
  localparam int K_W  = TH_W + 1;
  localparam int PR_W = DW + K_W;
  localparam int M_W  = PR_W + 1 - TH_W;

  localparam logic [PR_W:0]   RND_Y   = (PR_W + 1)'(1) << (TH_W - 1);
  localparam logic [M_W-1:0]  POS_LIM = (M_W'(1) << (DW - 1)) - 1'b1;
  localparam logic [M_W-1:0]  NEG_LIM = M_W'(1) << (DW - 1);
  localparam logic [DW-1:0]   Y_MAX   = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]   Y_MIN   = {1'b1, {(DW-1){1'b0}}};

  gelu_ctl_t        in_ctl_r;
  logic [DW-1:0]    in_a_r;
  gelu_ctl_t        cube_ctl, tanh_ctl;
  logic [DW-1:0]    cube_a, tanh_a;
  logic [U_W-1:0]   cube_u;
  logic [TH_W-1:0]  tanh_th;

  gelu_ctl_t        pr_ctl_r;
  logic [PR_W-1:0]  prod_r, prod_nxt;
  logic [K_W-1:0]   k;
  logic [PR_W:0]    ys;
  logic [M_W-1:0]   mag, mag_neg;
  logic [DW-1:0]    y_nxt;
  logic             out_valid_r;
  logic [DW-1:0]    out_y_r;

  // Pipeline never stalls
  assign busy = 1'b0;

  // Input stage: sign and magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
    end else begin
      in_ctl_r.valid <= start;
      in_ctl_r.neg   <= in_x_value[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    in_a_r <= in_x_value[DW-1] ? DW'(~in_x_value + 1'b1) : DW'(in_x_value);
  end

  gelu_cube #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cube (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (in_ctl_r),
    .a_i   (in_a_r),
    .ctl_o (cube_ctl),
    .a_o   (cube_a),
    .u_o   (cube_u)
  );

  gelu_tanh #(
    .DATA_WIDTH       (DATA_WIDTH),
    .FRAC_BITS        (FRAC_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_tanh (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (cube_ctl),
    .a_i   (cube_a),
    .u_i   (cube_u),
    .ctl_o (tanh_ctl),
    .a_o   (tanh_a),
    .th_o  (tanh_th)
  );

  // Product stage: |x| * (1 +/- tanh); odd symmetry folds the sign in here
  always_comb begin
    k = tanh_ctl.neg ? ({1'b0, TH_ONE} - {1'b0, tanh_th})
                     : ({1'b0, TH_ONE} + {1'b0, tanh_th});
    prod_nxt = PR_W'(tanh_a) * PR_W'(k);
  end

  // Output stage: round, restore sign, saturate
  always_comb begin
    ys      = {1'b0, prod_r} + RND_Y;
    mag     = ys[PR_W:TH_W];
    mag_neg = M_W'(0) - mag;
    if (pr_ctl_r.neg) begin
      y_nxt = (mag > NEG_LIM) ? Y_MIN : mag_neg[DW-1:0];
    end else begin
      y_nxt = (mag > POS_LIM) ? Y_MAX : mag[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pr_ctl_r    <= tanh_ctl;
      out_valid_r <= pr_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    out_y_r <= y_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_y_value = out_y_r;

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for gelu_tanh_forward: directed table, then randomised activations.
// Expected outputs come from a local fixed-point GELU predictor; depends on gelu_pkg.
module tb;

  localparam int DW    = gelu_pkg::DATA_WIDTH_DEF;
  localparam int FB    = gelu_pkg::FRAC_BITS_DEF;
  localparam int DEPTH = gelu_pkg::TANH_DEPTH_DEF;

  typedef longint unsigned u64_t;

  // Fixed-point constants of the tanh form
  localparam longint unsigned Q30_UNITY   = 64'd1 << 30;
  localparam longint unsigned TH_UNITY    = 64'd65536;      // 1.0 in Q16
  localparam longint unsigned COEF_OUTER  = 64'd836643;     // 0.797885 in Q20
  localparam longint unsigned COEF_CUBIC  = 64'd46887;      // 0.044715 in Q20
  localparam longint unsigned CUBE_SAT    = 64'd2147483647;
  localparam longint          Y_MAX       = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint          Y_MIN       = -(64'sd1 <<< (DW - 1));

  localparam int N_RANDOM      = 1630;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 1000;
  localparam int N_DIRECTED    = 22;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic signed [DW-1:0] in_x_value  = '0;
  logic                 busy;
  logic                 out_valid;
  logic signed [DW-1:0] out_y_value;

  // Expected output travelling with the request currently offered
  logic signed [DW-1:0] y_next = '0;
  logic signed [DW-1:0] y_due_q[$];
  int                   err_count   = 0;
  int                   idle_cycles = 0;

  longint unsigned tanh_q16 [DEPTH];

  // Directed row: activation, and an expected output where it is obvious by inspection
  typedef struct packed {
    logic [DW-1:0] x;
    logic          typed;
    logic [DW-1:0] y;
  } directed_row_t;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'h0000, 1'b1, 16'h0000},   // zero
    '{16'h0001, 1'b0, 16'h0000},   // smallest positive
    '{16'hFFFF, 1'b0, 16'h0000},   // smallest negative
    '{16'h7FFF, 1'b1, 16'h7FFF},   // largest positive, tanh saturated
    '{16'h8000, 1'b1, 16'h0000},   // most negative input
    '{16'h4000, 1'b1, 16'h4000},   // +4.0, well past the knee
    '{16'hC000, 1'b1, 16'h0000},   // -4.0
    '{16'h7000, 1'b1, 16'h7000},   // +7.0
    '{16'h1000, 1'b0, 16'h0000},   // +1.0
    '{16'hF000, 1'b0, 16'h0000},   // -1.0
    '{16'h0800, 1'b0, 16'h0000},
    '{16'hF800, 1'b0, 16'h0000},
    '{16'h2000, 1'b0, 16'h0000},
    '{16'hE000, 1'b0, 16'h0000},
    '{16'h3560, 1'b0, 16'h0000},   // last table segment, u just below 4
    '{16'h3585, 1'b0, 16'h0000},   // around u = 4
    '{16'h35A0, 1'b0, 16'h0000},   // just past tanh saturation
    '{16'hCA7B, 1'b0, 16'h0000},   // negative side of the knee
    '{16'h5555, 1'b0, 16'h0000},
    '{16'hAAAA, 1'b0, 16'h0000},
    '{16'h0010, 1'b0, 16'h0000},
    '{16'hFFF0, 1'b0, 16'h0000}
  };

  gelu_tanh_forward #(
    .DATA_WIDTH      (DW),
    .FRAC_BITS       (FB),
    .TANH_TABLE_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_x_value (in_x_value),
    .out_valid  (out_valid),
    .out_y_value(out_y_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Round half up by s bits
  function automatic longint unsigned round_shift(input longint unsigned v, input int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  // tanh samples over [0,4) in Q16: exp(-x/32) series, squared six times, then (1-e)/(1+e)
  function automatic void fill_tanh_table();
    longint unsigned r;
    longint unsigned e;
    longint unsigned term;
    longint unsigned num;
    longint unsigned den;
    for (int i = 0; i < DEPTH; i++) begin
      r    = (u64_t'(i) << 30) / (64'd8 * u64_t'(DEPTH));
      e    = Q30_UNITY;
      term = Q30_UNITY;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * r) >> 30) / u64_t'(k);
        if (k % 2 == 1) begin
          e = e - term;
        end else begin
          e = e + term;
        end
      end
      for (int s = 0; s < 6; s++) begin
        e = round_shift(e * e, 30);
      end
      num = (Q30_UNITY - e) << 16;
      den = Q30_UNITY + e;
      tanh_q16[i] = (num + den / 2) / den;
    end
  endfunction

  // Interpolated tanh of u (FB fractional bits), Q16, saturating to 1.0 from u = 4
  function automatic longint unsigned tanh_interp(input longint unsigned u);
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint          lo;
    longint          hi;
    longint          step;
    longint          th;
    if (u >= (64'd4 << FB)) begin
      return TH_UNITY;
    end
    pos  = u * u64_t'(DEPTH);
    idx  = pos >> (FB + 2);
    frac = pos & ((64'd1 << (FB + 2)) - 1);
    if (idx >= u64_t'(DEPTH)) begin
      return TH_UNITY;
    end
    lo = longint'(tanh_q16[idx]);
    // top segment closes on exactly 1.0
    hi = (idx + 1 < u64_t'(DEPTH)) ? longint'(tanh_q16[idx + 1])
                                   : longint'(TH_UNITY);
    step = hi - lo;
    if (step >= 0) begin
      th = lo + longint'(round_shift(u64_t'(step) * frac, FB + 2));
    end else begin
      th = lo - longint'(round_shift(u64_t'(-step) * frac, FB + 2));
    end
    if (th < 0) th = 0;
    if (th > longint'(TH_UNITY)) th = longint'(TH_UNITY);
    return u64_t'(th);
  endfunction

  // Expected GELU of one activation, worked on |x| with the sign restored at the end
  function automatic logic signed [DW-1:0] gelu_expect(input logic signed [DW-1:0] x);
    longint unsigned raw;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned cube;
    longint unsigned inner;
    longint unsigned u;
    longint unsigned th;
    longint          y;
    logic            neg;
    raw = unsigned'(x);
    neg = x[DW-1];
    mag = neg ? ((64'd1 << DW) - raw) : raw;
    sq  = round_shift(mag * mag, FB);
    if (sq > CUBE_SAT) sq = CUBE_SAT;
    cube = round_shift(sq * mag, FB);
    if (cube > CUBE_SAT) cube = CUBE_SAT;
    inner = mag + round_shift(cube * COEF_CUBIC, 20);
    u     = round_shift(inner * COEF_OUTER, 20);
    th    = tanh_interp(u);
    if (neg) begin
      y = -longint'(round_shift(mag * (TH_UNITY - th), 17));
    end else begin
      y = longint'(round_shift(mag * (TH_UNITY + th), 17));
    end
    if (y > Y_MAX) y = Y_MAX;
    if (y < Y_MIN) y = Y_MIN;
    return y[DW-1:0];
  endfunction

  // Idle cycles before the next request: mostly none, a few long
  function automatic int next_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until the edge that takes it
  task automatic send_request(input logic signed [DW-1:0] x,
                              input logic signed [DW-1:0] y_exp);
    start      <= 1'b1;
    in_x_value <= x;
    y_next     <= y_exp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Check results against the oldest expectation; book accepted requests; watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        $error("out_valid: expected 0 or 1, got %b", out_valid);
        err_count++;
      end else if (out_valid) begin
        if (y_due_q.size() == 0) begin
          $error("y_value: expected none, got %0d", out_y_value);
          err_count++;
        end else if (out_y_value !== y_due_q[0]) begin
          $error("y_value: expected %0d, got %0d", y_due_q[0], out_y_value);
          err_count++;
          void'(y_due_q.pop_front());
        end else begin
          void'(y_due_q.pop_front());
        end
      end
      if (start && !busy) begin
        y_due_q.push_back(y_next);
      end
      if ((start && !busy) || out_valid === 1'b1) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, random activations, drain
  initial begin
    int                   gap;
    bit                   burst;
    int                   burst_left;
    int                   sel;
    int                   val;
    logic signed [DW-1:0] x;
    burst      = 1'b0;
    burst_left = 0;
    fill_tanh_table();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      x = directed_rows[i].x;
      send_request(x, directed_rows[i].typed ? directed_rows[i].y : gelu_expect(x));
      gap = next_gap(1'b0);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    // random part; stretches of back-to-back requests are mixed at random with gappy ones
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst_left == 0) begin
        burst      = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(20, 120);
      end
      burst_left--;
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        val = $urandom_range(0, 65535);                        // whole range
      end else if (sel < 75) begin
        val = int'($urandom_range(0, 40960)) - 20480;          // +-5.0
      end else if (sel < 90) begin
        val = int'($urandom_range(0, 1200)) - 600;             // near zero
      end else begin
        val = 13701 + int'($urandom_range(0, 1600)) - 800;     // tanh knee
        if ($urandom_range(0, 1) == 1) val = -val;
      end
      x = val[DW-1:0];
      send_request(x, gelu_expect(x));
      gap = next_gap(burst);
      if (gap > 0 && n != N_RANDOM - 1) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    // wait for outstanding results, then for the drain period to catch strays
    while (y_due_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (y_due_q.size() > 0) begin
      $error("y_value: expected %0d, got nothing", y_due_q[0]);
      err_count++;
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
